// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
// every module that uses them has ports named clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that holds at every clock edge out of reset
`define CHK_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// an implication within the same cycle
`define CHK_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// an implication into the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gwuc_pkg.sv =====
package gwuc_pkg;

   // field widths
   localparam int WEEK_W = 16;
   localparam int MS_W   = 31;
   localparam int SECS_W = 22;
   localparam int DAYS_W = 19;
   localparam int YR_W   = 12;
   localparam int STEP_W = 4;

   // ms to seconds by reciprocal: floor(ms / 1000) = (ms * RECIP) >> RECIP_SHIFT
   localparam int RECIP_W     = 32;
   localparam int PROD_W      = MS_W + RECIP_W;
   localparam int RECIP_SHIFT = 41;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 32'd2199023256;

   localparam logic [SECS_W-1:0] SECS_PER_WEEK = 22'd604800;
   localparam logic [SECS_W-1:0] SECS_PER_DAY  = 22'd86400;
   localparam logic [SECS_W-1:0] SECS_PER_HOUR = 22'd3600;
   localparam logic [SECS_W-1:0] SECS_PER_MIN  = 22'd60;

   localparam logic [DAYS_W-1:0] EPOCH_DAY_OFFSET = 19'd5;
   localparam logic [DAYS_W-1:0] DAYS_PER_QUAD    = 19'd1461;
   localparam logic [YR_W-1:0]   EPOCH_YEAR       = 12'd1980;
   localparam logic [7:0]        YEAR_BASE_LO     = 8'hD0;  // low byte of 2000

   // month lengths; out-of-range month codes read as january
   localparam logic [4:0] MONTH_LEN [16] = '{
      5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
   };

   function automatic logic [4:0] month_len(input logic [1:0] yr_lo, input logic [3:0] mo);
      logic [4:0] len;
      len = MONTH_LEN[mo];
      if (mo == 4'd2 && yr_lo == 2'b00) begin
         len = len + 5'd1;
      end
      return len;
   endfunction

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_SECS, OP_ROLL, OP_INIT, OP_QUAD, OP_YEAR,
      OP_MONTH, OP_FILL, OP_COPY, OP_DAY, OP_HOUR, OP_MIN, OP_EMIT
   } op_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_NO_REQ, C_HIT, C_QUAD, C_YEAR,
      C_MONTH, C_DAY, C_HOUR, C_MIN, C_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } uword_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic cache_hit;
      logic ge_quad;
      logic ge_year;
      logic ge_month;
      logic ge_day;
      logic ge_hour;
      logic ge_min;
   } status_type;

   typedef struct packed {
      logic [7:0] year_since_2000;
      logic [3:0] month_of_year;
      logic [4:0] day_of_month;
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic [5:0] second_of_minute;
   } result_type;

   // program steps
   localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] ST_SECS  = 4'd1;
   localparam logic [STEP_W-1:0] ST_ROLL  = 4'd2;
   localparam logic [STEP_W-1:0] ST_INIT  = 4'd3;
   localparam logic [STEP_W-1:0] ST_QUAD  = 4'd4;
   localparam logic [STEP_W-1:0] ST_YEAR  = 4'd5;
   localparam logic [STEP_W-1:0] ST_MONTH = 4'd6;
   localparam logic [STEP_W-1:0] ST_FILL  = 4'd7;
   localparam logic [STEP_W-1:0] ST_COPY  = 4'd8;
   localparam logic [STEP_W-1:0] ST_DAY   = 4'd9;
   localparam logic [STEP_W-1:0] ST_HOUR  = 4'd10;
   localparam logic [STEP_W-1:0] ST_MIN   = 4'd11;
   localparam logic [STEP_W-1:0] ST_EMIT  = 4'd12;
   localparam logic [STEP_W-1:0] ST_DONE  = 4'd13;

   // control store: jump to target when cond holds, else next step
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      unique case (step)
         ST_IDLE:  w = '{OP_LOAD,  C_NO_REQ, ST_IDLE};
         ST_SECS:  w = '{OP_SECS,  C_NEVER,  ST_IDLE};
         ST_ROLL:  w = '{OP_ROLL,  C_NEVER,  ST_IDLE};
         ST_INIT:  w = '{OP_INIT,  C_HIT,    ST_COPY};
         ST_QUAD:  w = '{OP_QUAD,  C_QUAD,   ST_QUAD};
         ST_YEAR:  w = '{OP_YEAR,  C_YEAR,   ST_YEAR};
         ST_MONTH: w = '{OP_MONTH, C_MONTH,  ST_MONTH};
         ST_FILL:  w = '{OP_FILL,  C_ALWAYS, ST_DAY};
         ST_COPY:  w = '{OP_COPY,  C_NEVER,  ST_IDLE};
         ST_DAY:   w = '{OP_DAY,   C_DAY,    ST_DAY};
         ST_HOUR:  w = '{OP_HOUR,  C_HOUR,   ST_HOUR};
         ST_MIN:   w = '{OP_MIN,   C_MIN,    ST_MIN};
         ST_EMIT:  w = '{OP_EMIT,  C_BUSY,   ST_EMIT};
         ST_DONE:  w = '{OP_NOP,   C_ALWAYS, ST_IDLE};
         default:  w = '{OP_NOP,   C_ALWAYS, ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/gps_week_to_utc_calendar.sv =====
// sequence: a cached week runs the seconds, roll, init and copy steps, then the day,
//   hour and minute steps walk the whole days, hours and minutes in the time of week, then emit
// a new week adds the start-date walk over four-year spans, years and months, then the fill step
// one item at a time: the next is taken at the idle step, after its result is registered and the done step
// reset: sequencer to idle, week cache emptied, output register empty
module gps_week_to_utc_calendar
   import gwuc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WEEK_W-1:0] req_gps_week,
   input  logic [MS_W-1:0]   req_time_of_week_ms,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_year_since_2000,
   output logic [3:0]        rsp_month_of_year,
   output logic [4:0]        rsp_day_of_month,
   output logic [4:0]        rsp_hour_of_day,
   output logic [5:0]        rsp_minute_of_hour,
   output logic [5:0]        rsp_second_of_minute
);

   op_type     op;
   status_type status;
   result_type result;
   logic       req_take;
   logic       out_busy;
   logic       rsp_load;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   // input handshake: items enter only at the idle step
   assign req_stall = (op != OP_LOAD);
   assign req_take  = req_valid && !req_stall;

   // output register occupancy
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_load = (op == OP_EMIT) && !out_busy;

   gwuc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_avail (req_valid),
      .out_busy  (out_busy),
      .status    (status),
      .op        (op)
   );

   gwuc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .op                  (op),
      .req_take            (req_take),
      .req_gps_week        (req_gps_week),
      .req_time_of_week_ms (req_time_of_week_ms),
      .status              (status),
      .result              (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_year_since_2000  = rsp_data_ff.year_since_2000;
   assign rsp_month_of_year    = rsp_data_ff.month_of_year;
   assign rsp_day_of_month     = rsp_data_ff.day_of_month;
   assign rsp_hour_of_day      = rsp_data_ff.hour_of_day;
   assign rsp_minute_of_hour   = rsp_data_ff.minute_of_hour;
   assign rsp_second_of_minute = rsp_data_ff.second_of_minute;

endmodule

// ===== rtl/gwuc_seq.sv =====
`include "assert_macros.svh"

module gwuc_seq
   import gwuc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_avail,
   input  logic       out_busy,
   input  status_type status,
   output op_type     op
);

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   uword_type         uword;
   logic              take_jump;

   assign uword = ucode(pc_ff);
   assign op    = uword.op;

   // condition select
   always_comb begin
      unique case (uword.cond)
         C_NEVER:  take_jump = 1'b0;
         C_ALWAYS: take_jump = 1'b1;
         C_NO_REQ: take_jump = !req_avail;
         C_HIT:    take_jump = status.cache_hit;
         C_QUAD:   take_jump = status.ge_quad;
         C_YEAR:   take_jump = status.ge_year;
         C_MONTH:  take_jump = status.ge_month;
         C_DAY:    take_jump = status.ge_day;
         C_HOUR:   take_jump = status.ge_hour;
         C_MIN:    take_jump = status.ge_min;
         C_BUSY:   take_jump = out_busy;
         default:  take_jump = 1'b1;
      endcase
   end

   // step counter
   always_comb begin
      if (take_jump) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `CHK_ALWAYS(a_pc_in_program, pc_ff <= ST_DONE, "step counter left the program")
   `CHK_NEXT(a_accept_starts, (pc_ff == ST_IDLE) && req_avail, pc_ff == ST_SECS, "item accepted but sequence not started")

endmodule

// ===== rtl/gwuc_dp.sv =====
`include "assert_macros.svh"

module gwuc_dp
   import gwuc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  op_type            op,
   input  logic              req_take,
   input  logic [WEEK_W-1:0] req_gps_week,
   input  logic [MS_W-1:0]   req_time_of_week_ms,
   output status_type        status,
   output result_type        result
);

   // working registers
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WEEK_W-1:0] week_ff, week_in;
   logic [SECS_W-1:0] secs_ff, secs_in;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [YR_W-1:0]   yr_ff, yr_in;
   logic [3:0]        mo_ff, mo_in;
   logic [4:0]        dy_ff, dy_in;
   logic [4:0]        hr_ff, hr_in;
   logic [5:0]        mi_ff, mi_in;

   // week start cache
   logic              cache_valid_ff, cache_valid_in;
   logic [WEEK_W-1:0] cached_week_ff, cached_week_in;
   logic [YR_W-1:0]   cached_year_ff, cached_year_in;
   logic [3:0]        cached_month_ff, cached_month_in;
   logic [4:0]        cached_day_ff, cached_day_in;

   logic [8:0]        ylen;
   logic [4:0]        mlen;
   logic [5:0]        dy_inc;

   // flags for the sequencer
   always_comb begin
      ylen = (yr_ff[1:0] == 2'b00) ? 9'd366 : 9'd365;
      mlen = month_len(yr_ff[1:0], mo_ff);
      dy_inc = {1'b0, dy_ff} + 6'd1;
      status.cache_hit = cache_valid_ff && (week_ff == cached_week_ff);
      status.ge_quad   = days_ff >= DAYS_PER_QUAD;
      status.ge_year   = days_ff >= {10'b0, ylen};
      status.ge_month  = days_ff >= {14'b0, mlen};
      status.ge_day    = secs_ff >= SECS_PER_DAY;
      status.ge_hour   = secs_ff >= SECS_PER_HOUR;
      status.ge_min    = secs_ff >= SECS_PER_MIN;
   end

   // datapath operation decode
   always_comb begin
      prod_in         = prod_ff;
      week_in         = week_ff;
      secs_in         = secs_ff;
      days_in         = days_ff;
      yr_in           = yr_ff;
      mo_in           = mo_ff;
      dy_in           = dy_ff;
      hr_in           = hr_ff;
      mi_in           = mi_ff;
      cache_valid_in  = cache_valid_ff;
      cached_week_in  = cached_week_ff;
      cached_year_in  = cached_year_ff;
      cached_month_in = cached_month_ff;
      cached_day_in   = cached_day_ff;
      unique case (op)
         OP_LOAD: begin
            if (req_take) begin
               prod_in = {{RECIP_W{1'b0}}, req_time_of_week_ms} *
                         {{MS_W{1'b0}}, RECIP_1000};
               week_in = req_gps_week;
               hr_in   = 5'd0;
               mi_in   = 6'd0;
            end
         end
         OP_SECS: secs_in = prod_ff[RECIP_SHIFT +: SECS_W];
         OP_ROLL: begin
            if (secs_ff >= SECS_PER_WEEK) begin
               secs_in = secs_ff - SECS_PER_WEEK;
               week_in = week_ff + 16'd1;
            end
         end
         OP_INIT: begin
            days_in = ({3'b0, week_ff} << 3) - {3'b0, week_ff} + EPOCH_DAY_OFFSET;
            yr_in   = EPOCH_YEAR;
            mo_in   = 4'd1;
         end
         OP_QUAD: begin
            if (status.ge_quad) begin
               days_in = days_ff - DAYS_PER_QUAD;
               yr_in   = yr_ff + 12'd4;
            end
         end
         OP_YEAR: begin
            if (status.ge_year) begin
               days_in = days_ff - {10'b0, ylen};
               yr_in   = yr_ff + 12'd1;
            end
         end
         OP_MONTH: begin
            if (status.ge_month) begin
               days_in = days_ff - {14'b0, mlen};
               mo_in   = mo_ff + 4'd1;
            end
         end
         OP_FILL: begin
            dy_in           = days_ff[4:0] + 5'd1;
            cache_valid_in  = 1'b1;
            cached_week_in  = week_ff;
            cached_year_in  = yr_ff;
            cached_month_in = mo_ff;
            cached_day_in   = days_ff[4:0] + 5'd1;
         end
         OP_COPY: begin
            yr_in = cached_year_ff;
            mo_in = cached_month_ff;
            dy_in = cached_day_ff;
         end
         OP_DAY: begin
            if (status.ge_day) begin
               secs_in = secs_ff - SECS_PER_DAY;
               if (dy_inc > {1'b0, mlen}) begin
                  dy_in = 5'd1;
                  if (mo_ff >= 4'd12) begin
                     mo_in = 4'd1;
                     yr_in = yr_ff + 12'd1;
                  end else begin
                     mo_in = mo_ff + 4'd1;
                  end
               end else begin
                  dy_in = dy_inc[4:0];
               end
            end
         end
         OP_HOUR: begin
            if (status.ge_hour) begin
               secs_in = secs_ff - SECS_PER_HOUR;
               hr_in   = hr_ff + 5'd1;
            end
         end
         OP_MIN: begin
            if (status.ge_min) begin
               secs_in = secs_ff - SECS_PER_MIN;
               mi_in   = mi_ff + 6'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      week_ff <= week_in;
      secs_ff <= secs_in;
      days_ff <= days_in;
      yr_ff   <= yr_in;
      mo_ff   <= mo_in;
      dy_ff   <= dy_in;
      hr_ff   <= hr_in;
      mi_ff   <= mi_in;
   end

   // cache registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_valid_ff  <= 1'b0;
         cached_week_ff  <= '0;
         cached_year_ff  <= '0;
         cached_month_ff <= '0;
         cached_day_ff   <= '0;
      end else begin
         cache_valid_ff  <= cache_valid_in;
         cached_week_ff  <= cached_week_in;
         cached_year_ff  <= cached_year_in;
         cached_month_ff <= cached_month_in;
         cached_day_ff   <= cached_day_in;
      end
   end

   // result fields
   always_comb begin
      result.year_since_2000  = yr_ff[7:0] - YEAR_BASE_LO;
      result.month_of_year    = mo_ff;
      result.day_of_month     = dy_ff;
      result.hour_of_day      = hr_ff;
      result.minute_of_hour   = mi_ff;
      result.second_of_minute = secs_ff[5:0];
   end

   `CHK_IMPL(a_month_range, op == OP_EMIT, (mo_ff >= 4'd1) && (mo_ff <= 4'd12), "month out of range at result")
   `CHK_IMPL(a_day_hour_range, op == OP_EMIT, (dy_ff != 5'd0) && (hr_ff <= 5'd23) && (secs_ff < SECS_PER_MIN), "day or time out of range at result")

endmodule
